// ===== src/abs_pkg.sv =====
// Package for the alternating-bit sender: event and acknowledgement codes,
// result and control structures, and fixed widths. Depends on nothing.
`default_nettype none

package abs_pkg;

    localparam int TAG_W     = 32;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int INIT_W    = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [INIT_W-1:0] INIT_TIMEOUT_RST = 16'd1000;

    typedef enum logic [1:0] {
        FUNC_MSG   = 2'd0,
        FUNC_ACK   = 2'd1,
        FUNC_TIMER = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACK_NEG   = 2'd0,
        ACK_POS   = 2'd1,
        ACK_OTHER = 2'd2,
        ACK_RSVD  = 2'd3
    } ack_kind_t;

    typedef enum logic [0:0] {
        REG_INITIAL_TIMEOUT = 1'b0,
        REG_UNMAPPED        = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              send_valid;
        logic              send_seq;
        logic [TAG_W-1:0]  send_tag;
        logic              is_resend;
        logic              timer_start;
        logic              timer_stop;
        logic [TIME_W-1:0] timer_duration;
        logic [CNT_W-1:0]  success_count;
        logic              queue_dropped;
    } result_t;

    typedef struct packed {
        logic              load;
        logic [TIME_W-1:0] value;
    } cfg_wr_t;

    typedef struct packed {
        logic push;
        logic pop;
    } bl_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } bl_stat_t;

endpackage

`default_nettype wire

// ===== src/abs_in_if.sv =====
// Input channel of the alternating-bit sender: valid/ready plus event fields.
// Depends on abs_pkg for field widths.
`default_nettype none

interface abs_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic [abs_pkg::TAG_W-1:0] msg_tag;
    logic                     ack_checksum_ok;
    logic                     ack_number;
    logic [1:0]               ack_kind;

    modport source (
        output valid, func, msg_tag, ack_checksum_ok, ack_number, ack_kind,
        input  ready
    );
    modport sink (
        input  valid, func, msg_tag, ack_checksum_ok, ack_number, ack_kind,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/abs_out_if.sv =====
// Output channel of the alternating-bit sender: valid/ready plus result fields.
// Depends on abs_pkg for field widths.
`default_nettype none

interface abs_out_if;
    logic                       valid;
    logic                       ready;
    logic                       send_valid;
    logic                       send_seq;
    logic [abs_pkg::TAG_W-1:0]  send_tag;
    logic                       is_resend;
    logic                       timer_start;
    logic                       timer_stop;
    logic [abs_pkg::TIME_W-1:0] timer_duration;
    logic [abs_pkg::CNT_W-1:0]  success_count;
    logic                       queue_dropped;

    modport source (
        output valid, send_valid, send_seq, send_tag, is_resend, timer_start,
               timer_stop, timer_duration, success_count, queue_dropped,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_seq, send_tag, is_resend, timer_start,
               timer_stop, timer_duration, success_count, queue_dropped,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/abs_cfg.sv =====
// APB-style configuration register holding the initial timeout.
// Depends on abs_pkg for widths, register indexes and the write structure.
`default_nettype none

module abs_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [abs_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [abs_pkg::PDATA_W-1:0]   pwdata,
    output logic      [abs_pkg::PDATA_W-1:0]   prdata,
    output abs_pkg::cfg_wr_t                   cfg_wr
);

    logic [abs_pkg::INIT_W-1:0] init_timeout_reg;
    logic [abs_pkg::INIT_W-1:0] init_timeout_next;
    logic                       sel_init;
    logic                       wr_en;

    assign sel_init = (abs_pkg::reg_idx_t'(paddr[abs_pkg::PADDR_W-1])
                       == abs_pkg::REG_INITIAL_TIMEOUT);
    assign wr_en    = psel && penable && pwrite && sel_init;

    // A zero timeout is stored as one tick.
    always_comb
    begin
        init_timeout_next = pwdata[abs_pkg::INIT_W-1:0];
        if (init_timeout_next == '0)
        begin
            init_timeout_next = abs_pkg::INIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_timeout_reg <= abs_pkg::INIT_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            init_timeout_reg <= init_timeout_next;
        end
    end

    assign prdata       = sel_init ? abs_pkg::PDATA_W'(init_timeout_reg) : '0;
    assign cfg_wr.load  = wr_en;
    assign cfg_wr.value = abs_pkg::TIME_W'(init_timeout_next);

endmodule

`default_nettype wire

// ===== src/abs_backlog.sv =====
// Backlog queue in a synchronous memory with a prefetched head entry.
// Depends on abs_pkg for the control and status structures.
`default_nettype none

module abs_backlog #(
    parameter int QUEUE_DEPTH = 8,
    parameter int DATA_BITS   = 33
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire abs_pkg::bl_ctrl_t    ctrl,
    input  wire logic [DATA_BITS-1:0] push_data,
    output logic      [DATA_BITS-1:0] head_data,
    output abs_pkg::bl_stat_t         stat
);

    localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int SumW = CntW + 1;

    logic [DATA_BITS-1:0] mem [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] head_data_reg;
    logic [IdxW-1:0]      head_reg;
    logic [IdxW-1:0]      head_next;
    logic [IdxW-1:0]      head_inc;
    logic [CntW-1:0]      count_reg;
    logic [CntW-1:0]      count_next;
    logic [SumW-1:0]      tail_sum;
    logic [IdxW-1:0]      tail;
    logic [IdxW-1:0]      rd_addr;

    assign head_inc = (head_reg == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IdxW'(1);

    always_comb
    begin
        tail_sum = SumW'(head_reg) + SumW'(count_reg);
        if (tail_sum >= SumW'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SumW'(QUEUE_DEPTH);
        end
        tail = tail_sum[IdxW-1:0];
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = head_inc;
            count_next = count_reg - CntW'(1);
        end
        else if (ctrl.push)
        begin
            count_next = count_reg + CntW'(1);
        end
    end

    assign rd_addr = head_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // A push into an empty queue lands on the head slot and is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= push_data;
        end
        if (ctrl.push && (tail == rd_addr))
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem[rd_addr];
        end
    end

    assign head_data  = head_data_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CntW'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== src/abs_obuf.sv =====
// Two-entry output buffer that decouples result transfers from input transfers.
// Depends on abs_pkg for the result structure.
`default_nettype none

module abs_obuf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire abs_pkg::result_t push_data,
    output logic                  can_push,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output abs_pkg::result_t      out_data
);

    abs_pkg::result_t slot0_reg;
    abs_pkg::result_t slot1_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign can_push  = (count_reg != 2'd2);
    assign out_data  = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            slot0_reg <= (push && (count_reg == 2'd1)) ? push_data : slot1_reg;
            if (push && (count_reg == 2'd2))
            begin
                slot1_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_data;
            end
            else
            begin
                slot1_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/alternating_bit_sender.sv =====
// Top level of the alternating-bit sender: event handling, held packet and timer state.
// Depends on abs_pkg, abs_in_if, abs_out_if, abs_cfg, abs_backlog and abs_obuf.
//
//   Channel   Direction  Handshake              Contents
//   in_ch     sink       valid/ready            func, msg_tag, ack fields
//   out_ch    source     valid/ready            send, timer and status fields
//   APB       slave      psel/penable/pready    initial_timeout at byte address 0
//
// One event is taken per cycle while the output buffer has room; its result is registered into that buffer.
// The backlog head is prefetched from the queue memory each cycle, so a pop needs no wait.
// A two-entry output buffer holds the waiting result plus one more, so in steady streaming
// input transfers continue into an output stall until both entries are full and then pause.
// Reset clears all control state and sets the timeout to 1000; no clearing pass is needed.
`default_nettype none

module alternating_bit_sender #(
    parameter int QUEUE_DEPTH = 8,
    parameter int TAG_BITS    = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    abs_in_if.sink                           in_ch,
    abs_out_if.source                        out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [abs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [abs_pkg::PDATA_W-1:0] pwdata,
    output logic      [abs_pkg::PDATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int TagW      = abs_pkg::TAG_W;
    localparam int TimeW     = abs_pkg::TIME_W;
    localparam int CntW      = abs_pkg::CNT_W;
    localparam int StoreBits = (TAG_BITS < TagW) ? TAG_BITS : TagW;
    localparam int EntryW    = StoreBits + 1;

    abs_pkg::cfg_wr_t  cfg_wr;
    abs_pkg::bl_ctrl_t bl_ctrl;
    abs_pkg::bl_stat_t bl_stat;
    abs_pkg::result_t  res;
    abs_pkg::result_t  out_data;

    logic [EntryW-1:0]    head_entry;
    logic [StoreBits-1:0] in_tag;
    logic                 accept;
    logic                 can_push;
    logic                 bad_ack;

    logic                 next_bit_reg;
    logic                 next_bit_next;
    logic                 awaited_reg;
    logic                 awaited_next;
    logic                 held_seq_reg;
    logic                 held_seq_next;
    logic [StoreBits-1:0] held_tag_reg;
    logic [StoreBits-1:0] held_tag_next;
    logic                 idle_reg;
    logic                 idle_next;
    logic [TimeW-1:0]     timeout_reg;
    logic [TimeW-1:0]     timeout_next;
    logic [CntW-1:0]      good_acks_reg;
    logic [CntW-1:0]      good_acks_next;

    abs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg_wr  (cfg_wr)
    );

    assign pready = 1'b1;

    abs_backlog #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_BITS   (EntryW)
    ) u_backlog (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (bl_ctrl),
        .push_data ({next_bit_reg, in_tag}),
        .head_data (head_entry),
        .stat      (bl_stat)
    );

    assign in_ch.ready = can_push;
    assign accept      = in_ch.valid && can_push;
    assign in_tag      = StoreBits'(in_ch.msg_tag);
    assign bad_ack     = !in_ch.ack_checksum_ok || (in_ch.ack_number != awaited_reg)
                         || (abs_pkg::ack_kind_t'(in_ch.ack_kind) == abs_pkg::ACK_NEG);

    always_comb
    begin
        next_bit_next  = next_bit_reg;
        awaited_next   = awaited_reg;
        held_seq_next  = held_seq_reg;
        held_tag_next  = held_tag_reg;
        idle_next      = idle_reg;
        timeout_next   = timeout_reg;
        good_acks_next = good_acks_reg;
        bl_ctrl        = '0;
        res            = '0;

        if (accept)
        begin
            unique case (abs_pkg::func_t'(in_ch.func))
                abs_pkg::FUNC_MSG:
                begin
                    if (idle_reg)
                    begin
                        idle_next       = 1'b0;
                        held_seq_next   = next_bit_reg;
                        held_tag_next   = in_tag;
                        awaited_next    = next_bit_reg;
                        res.send_valid  = 1'b1;
                        res.timer_start = 1'b1;
                    end
                    else if (bl_stat.full)
                    begin
                        res.queue_dropped = 1'b1;
                    end
                    else
                    begin
                        bl_ctrl.push = 1'b1;
                    end
                    next_bit_next = !next_bit_reg;
                end
                abs_pkg::FUNC_ACK:
                begin
                    if (bad_ack)
                    begin
                        res.send_valid = 1'b1;
                        res.is_resend  = 1'b1;
                    end
                    else if (abs_pkg::ack_kind_t'(in_ch.ack_kind) == abs_pkg::ACK_POS)
                    begin
                        good_acks_next = good_acks_reg + CntW'(1);
                        res.timer_stop = 1'b1;
                        if (!bl_stat.empty)
                        begin
                            bl_ctrl.pop     = 1'b1;
                            held_seq_next   = head_entry[EntryW-1];
                            held_tag_next   = head_entry[StoreBits-1:0];
                            awaited_next    = head_entry[EntryW-1];
                            res.send_valid  = 1'b1;
                            res.timer_start = 1'b1;
                        end
                        else
                        begin
                            idle_next = 1'b1;
                        end
                    end
                end
                abs_pkg::FUNC_TIMER:
                begin
                    if (timeout_reg[TimeW-1])
                    begin
                        timeout_next = '1;
                    end
                    else
                    begin
                        timeout_next = {timeout_reg[TimeW-2:0], 1'b0};
                    end
                    res.send_valid  = 1'b1;
                    res.is_resend   = 1'b1;
                    res.timer_start = 1'b1;
                end
                abs_pkg::FUNC_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_wr.load)
        begin
            timeout_next = cfg_wr.value;
        end

        if (res.send_valid)
        begin
            res.send_seq = held_seq_next;
            res.send_tag = TagW'(held_tag_next);
        end
        res.timer_duration = timeout_next;
        res.success_count  = good_acks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_bit_reg  <= 1'b0;
            awaited_reg   <= 1'b0;
            held_seq_reg  <= 1'b0;
            held_tag_reg  <= '0;
            idle_reg      <= 1'b1;
            timeout_reg   <= TimeW'(abs_pkg::INIT_TIMEOUT_RST);
            good_acks_reg <= '0;
        end
        else
        begin
            next_bit_reg  <= next_bit_next;
            awaited_reg   <= awaited_next;
            held_seq_reg  <= held_seq_next;
            held_tag_reg  <= held_tag_next;
            idle_reg      <= idle_next;
            timeout_reg   <= timeout_next;
            good_acks_reg <= good_acks_next;
        end
    end

    abs_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.send_valid     = out_data.send_valid;
    assign out_ch.send_seq       = out_data.send_seq;
    assign out_ch.send_tag       = out_data.send_tag;
    assign out_ch.is_resend      = out_data.is_resend;
    assign out_ch.timer_start    = out_data.timer_start;
    assign out_ch.timer_stop     = out_data.timer_stop;
    assign out_ch.timer_duration = out_data.timer_duration;
    assign out_ch.success_count  = out_data.success_count;
    assign out_ch.queue_dropped  = out_data.queue_dropped;

endmodule

`default_nettype wire

// ===== dv/alternating_bit_sender_tb.sv =====
// Self-checking testbench for alternating_bit_sender: directed table, then random event streams.
// Depends on abs_pkg, abs_in_if, abs_out_if and the alternating_bit_sender RTL.
`default_nettype none

module alternating_bit_sender_tb;
    import abs_pkg::*;

    localparam int QDEPTH     = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 160;

    typedef struct {
        func_t       func;
        logic [31:0] tag;
        logic        ck_ok;
        logic        ack_no;
        ack_kind_t   kind;
        bit          typed;
        result_t     res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    abs_in_if  in_ch();
    abs_out_if out_ch();

    alternating_bit_sender dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Shadow state of the sender.
    logic [INIT_W-1:0] init_timeout = INIT_TIMEOUT_RST;
    logic              next_bit     = 1'b0;
    logic              awaited_no   = 1'b0;
    logic              held_seq     = 1'b0;
    logic [31:0]       held_tag     = '0;
    logic              snd_idle     = 1'b1;
    logic              bl_seq [QDEPTH];
    logic [31:0]       bl_tag [QDEPTH];
    logic [2:0]        bl_head      = '0;
    logic [3:0]        bl_count     = '0;
    logic [31:0]       timeout_now  = 32'(INIT_TIMEOUT_RST);
    logic [31:0]       good_acks    = '0;

    result_t   pending_sends [$];
    stim_row_t dir_rows [$];
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        run_left = 0;
    func_t     run_func = FUNC_MSG;
    int        rx_stall = 0;
    int        rx_mode = 0;
    int        rx_cycle = 0;

    function automatic void emit_held(inout result_t r, input logic resend);
        r.send_valid = 1'b1;
        r.send_seq   = held_seq;
        r.send_tag   = held_tag;
        r.is_resend  = resend;
    endfunction

    function automatic result_t predict_send(func_t f, logic [31:0] tag, logic ck_ok,
                                             logic ack_no, ack_kind_t kind);
        result_t    r;
        logic [2:0] slot;
        r = '0;
        case (f)
            FUNC_MSG:
            begin
                if (snd_idle)
                begin
                    snd_idle   = 1'b0;
                    held_seq   = next_bit;
                    held_tag   = tag;
                    awaited_no = next_bit;
                    emit_held(r, 1'b0);
                    r.timer_start = 1'b1;
                end
                else if (bl_count >= QDEPTH)
                begin
                    r.queue_dropped = 1'b1;
                end
                else
                begin
                    slot = bl_head + bl_count[2:0];
                    bl_seq[slot] = next_bit;
                    bl_tag[slot] = tag;
                    bl_count = bl_count + 1;
                end
                next_bit = ~next_bit;
            end
            FUNC_ACK:
            begin
                if (!ck_ok || ack_no != awaited_no || kind == ACK_NEG)
                begin
                    emit_held(r, 1'b1);
                end
                else if (kind == ACK_POS)
                begin
                    good_acks = good_acks + 1;
                    r.timer_stop = 1'b1;
                    if (bl_count != 0)
                    begin
                        held_seq   = bl_seq[bl_head];
                        held_tag   = bl_tag[bl_head];
                        awaited_no = held_seq;
                        bl_head    = bl_head + 1;
                        bl_count   = bl_count - 1;
                        emit_held(r, 1'b0);
                        r.timer_start = 1'b1;
                    end
                    else
                    begin
                        snd_idle = 1'b1;
                    end
                end
            end
            FUNC_TIMER:
            begin
                if (timeout_now >= 32'h8000_0000)
                    timeout_now = '1;
                else
                    timeout_now = timeout_now << 1;
                emit_held(r, 1'b1);
                r.timer_start = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.timer_duration = timeout_now;
        r.success_count  = good_acks;
        return r;
    endfunction

    function automatic result_t mk_res(logic sv, logic seq, logic [31:0] tag, logic rs,
                                       logic ts, logic tp, logic [31:0] dur,
                                       logic [31:0] cnt, logic drop);
        result_t r;
        r.send_valid     = sv;
        r.send_seq       = seq;
        r.send_tag       = tag;
        r.is_resend      = rs;
        r.timer_start    = ts;
        r.timer_stop     = tp;
        r.timer_duration = dur;
        r.success_count  = cnt;
        r.queue_dropped  = drop;
        return r;
    endfunction

    task automatic add_row(func_t f, logic [31:0] tag, logic ck_ok, logic ack_no,
                           ack_kind_t kind, bit typed, result_t res);
        stim_row_t row;
        row.func   = f;
        row.tag    = tag;
        row.ck_ok  = ck_ok;
        row.ack_no = ack_no;
        row.kind   = kind;
        row.typed  = typed;
        row.res    = res;
        dir_rows.push_back(row);
    endtask

    task automatic drain_sends();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_sends.size() != 0);
        @(posedge clk);
    endtask

    task automatic drive_event(func_t f, logic [31:0] tag, logic ck_ok, logic ack_no,
                               ack_kind_t kind, bit typed, result_t res,
                               output bit counted);
        result_t pred;
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid           <= 1'b1;
        in_ch.func            <= f;
        in_ch.msg_tag         <= tag;
        in_ch.ack_checksum_ok <= ck_ok;
        in_ch.ack_number      <= ack_no;
        in_ch.ack_kind        <= kind;
        do @(negedge clk); while (!in_ch.ready);
        @(posedge clk);
        pred = predict_send(f, tag, ck_ok, ack_no, kind);
        pending_sends.push_back(typed ? res : pred);
        counted = !(f == FUNC_NONE ||
                    (f == FUNC_ACK && !pred.send_valid && !pred.timer_stop));
    endtask

    task automatic write_initial_timeout(logic [15:0] value);
        drain_sends();
        repeat (6) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INITIAL_TIMEOUT, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        @(posedge clk);
        init_timeout = (value == 0) ? 16'd1 : value;
        timeout_now  = 32'(init_timeout);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        if (prdata !== 32'(init_timeout))
        begin
            $display("%0t: initial_timeout readback expected %h got %h",
                     $time, 32'(init_timeout), prdata);
            mismatch_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed traffic: messages and acks that match the awaited number,
    // with bursts of messages to fill the backlog and runs of expiries to saturate.
    task automatic pick_event(output func_t f, output logic [31:0] tag, output logic ck_ok,
                              output logic ack_no, output ack_kind_t kind);
        int p;
        tag    = $urandom;
        ck_ok  = 1'($urandom);
        ack_no = 1'($urandom);
        kind   = ack_kind_t'($urandom_range(0, 3));
        if (run_left > 0)
        begin
            run_left--;
            f = run_func;
        end
        else
        begin
            p = $urandom_range(0, 99);
            if (p < 5)
            begin
                run_func = FUNC_MSG;
                run_left = $urandom_range(7, 10);
                f = FUNC_MSG;
            end
            else if (p < 8)
            begin
                run_func = FUNC_TIMER;
                run_left = $urandom_range(15, 35);
                f = FUNC_TIMER;
            end
            else if (p < 12)
            begin
                f = func_t'($urandom_range(0, 3));
            end
            else if (p < 45)
            begin
                f = FUNC_MSG;
            end
            else if (p < 85)
            begin
                f = FUNC_ACK;
                if ($urandom_range(0, 9) < 7)
                begin
                    ck_ok  = 1'b1;
                    ack_no = awaited_no;
                    kind   = ACK_POS;
                end
            end
            else if (p < 95)
            begin
                f = FUNC_TIMER;
            end
            else
            begin
                f = FUNC_ACK;
            end
        end
    endtask

    task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %h got %h", $time, field, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_sends.size() == 0)
            begin
                $display("%0t: unexpected result, send_tag %h", $time, out_ch.send_tag);
                mismatch_count++;
            end
            else
            begin
                want = pending_sends.pop_front();
                check_field("send_valid", 32'(want.send_valid), 32'(out_ch.send_valid));
                check_field("send_seq", 32'(want.send_seq), 32'(out_ch.send_seq));
                check_field("send_tag", want.send_tag, out_ch.send_tag);
                check_field("is_resend", 32'(want.is_resend), 32'(out_ch.is_resend));
                check_field("timer_start", 32'(want.timer_start), 32'(out_ch.timer_start));
                check_field("timer_stop", 32'(want.timer_stop), 32'(out_ch.timer_stop));
                check_field("timer_duration", want.timer_duration, out_ch.timer_duration);
                check_field("success_count", want.success_count, out_ch.success_count);
                check_field("queue_dropped", 32'(want.queue_dropped),
                            32'(out_ch.queue_dropped));
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 256 == 0)
                rx_mode = $urandom_range(0, 2);
            if (rx_stall > 0)
            begin
                rx_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (rx_mode == 1 && $urandom_range(0, 2) == 0)
                    rx_stall = $urandom_range(1, 3);
                else if (rx_mode == 2 && $urandom_range(0, 19) == 0)
                    rx_stall = $urandom_range(5, 14);
            end
        end
    end

    initial
    begin
        func_t       f;
        logic [31:0] tag;
        logic        ck_ok;
        logic        ack_no;
        ack_kind_t   kind;
        bit          counted;
        int          done;
        logic [15:0] cfg_vals [5];

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.func            <= FUNC_NONE;
        in_ch.msg_tag         <= '0;
        in_ch.ack_checksum_ok <= 1'b0;
        in_ch.ack_number      <= 1'b0;
        in_ch.ack_kind        <= ACK_NEG;

        add_row(FUNC_NONE, 32'hFFFF_FFFF, 1, 1, ACK_RSVD, 1,
                mk_res(0, 0, 32'h0, 0, 0, 0, 32'd1000, 32'd0, 0));
        add_row(FUNC_ACK, 32'h0, 0, 0, ACK_POS, 1,
                mk_res(1, 0, 32'h0, 1, 0, 0, 32'd1000, 32'd0, 0));
        add_row(FUNC_ACK, 32'h0, 1, 0, ACK_POS, 1,
                mk_res(0, 0, 32'h0, 0, 0, 1, 32'd1000, 32'd1, 0));
        add_row(FUNC_MSG, 32'hFFFF_FFFF, 0, 1, ACK_OTHER, 1,
                mk_res(1, 0, 32'hFFFF_FFFF, 0, 1, 0, 32'd1000, 32'd1, 0));
        add_row(FUNC_MSG, 32'h0, 1, 0, ACK_NEG, 1,
                mk_res(0, 0, 32'h0, 0, 0, 0, 32'd1000, 32'd1, 0));
        add_row(FUNC_MSG, 32'h8000_0001, 0, 0, ACK_POS, 0, '0);
        add_row(FUNC_MSG, 32'h7FFF_FFFE, 1, 1, ACK_POS, 0, '0);
        add_row(FUNC_MSG, 32'h1234_5678, 0, 1, ACK_NEG, 0, '0);
        add_row(FUNC_MSG, 32'hA5A5_5A5A, 1, 0, ACK_RSVD, 0, '0);
        add_row(FUNC_MSG, 32'h0000_0001, 0, 0, ACK_OTHER, 0, '0);
        add_row(FUNC_MSG, 32'hFFFF_0000, 1, 1, ACK_RSVD, 0, '0);
        add_row(FUNC_MSG, 32'h0F0F_F0F0, 0, 1, ACK_POS, 0, '0);
        add_row(FUNC_MSG, 32'hDEAD_BEEF, 1, 0, ACK_POS, 1,
                mk_res(0, 0, 32'h0, 0, 0, 0, 32'd1000, 32'd1, 1));
        add_row(FUNC_ACK, 32'h0, 1, 0, ACK_OTHER, 1,
                mk_res(0, 0, 32'h0, 0, 0, 0, 32'd1000, 32'd1, 0));
        add_row(FUNC_ACK, 32'h0, 1, 0, ACK_RSVD, 1,
                mk_res(0, 0, 32'h0, 0, 0, 0, 32'd1000, 32'd1, 0));
        add_row(FUNC_ACK, 32'h0, 1, 0, ACK_NEG, 1,
                mk_res(1, 0, 32'hFFFF_FFFF, 1, 0, 0, 32'd1000, 32'd1, 0));
        add_row(FUNC_ACK, 32'h0, 1, 1, ACK_POS, 1,
                mk_res(1, 0, 32'hFFFF_FFFF, 1, 0, 0, 32'd1000, 32'd1, 0));
        add_row(FUNC_ACK, 32'h0, 1, 0, ACK_POS, 1,
                mk_res(1, 1, 32'h0, 0, 1, 1, 32'd1000, 32'd2, 0));
        add_row(FUNC_TIMER, 32'h0, 0, 0, ACK_NEG, 1,
                mk_res(1, 1, 32'h0, 1, 1, 0, 32'd2000, 32'd2, 0));
        add_row(FUNC_ACK, 32'h5555_AAAA, 1, 1, ACK_POS, 0, '0);
        add_row(FUNC_MSG, 32'h3C3C_C3C3, 1, 1, ACK_OTHER, 0, '0);
        add_row(FUNC_ACK, 32'h0, 0, 1, ACK_NEG, 0, '0);
        add_row(FUNC_NONE, 32'h0, 0, 0, ACK_NEG, 0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            drive_event(dir_rows[i].func, dir_rows[i].tag, dir_rows[i].ck_ok,
                        dir_rows[i].ack_no, dir_rows[i].kind, dir_rows[i].typed,
                        dir_rows[i].res, counted);

        cfg_vals[0] = 16'd0;
        cfg_vals[1] = 16'hFFFF;
        cfg_vals[2] = 16'd1;
        cfg_vals[3] = 16'($urandom_range(2, 65534));
        cfg_vals[4] = 16'($urandom_range(2, 300));

        foreach (cfg_vals[ph])
        begin
            write_initial_timeout(cfg_vals[ph]);
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                pick_event(f, tag, ck_ok, ack_no, kind);
                drive_event(f, tag, ck_ok, ack_no, kind, 0, '0, counted);
                if (counted)
                begin
                    done++;
                    if (done == PHASE_ITEMS / 2)
                        drain_sends();
                end
            end
        end

        drain_sends();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_sends.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== alternating_bit_sender.f =====
src/abs_pkg.sv
src/abs_in_if.sv
src/abs_out_if.sv
src/abs_cfg.sv
src/abs_backlog.sv
src/abs_obuf.sv
src/alternating_bit_sender.sv
dv/alternating_bit_sender_tb.sv
